@@ rtl/hgs_pkg.sv @@
`default_nettype none

package hgs_pkg;

  // Default store depth in pixels.
  localparam int PixelDepth = 65536;

  // Stream and register port widths.
  localparam int InDataW  = 72;
  localparam int OutDataW = 32;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;
  localparam int PixelW   = 24;

  // Brightness normalization: v = floor((s * 65536 + 382) / 765).
  // The division uses the rounded-up reciprocal of 2^36 / 765, which gives the
  // exact quotient for every numerator below 2^27.
  localparam int     NormDiv   = 765;
  localparam int     NormRound = 382;
  localparam int     NormShift = 36;
  localparam longint NormRecip = ((longint'(1) << NormShift) + NormDiv - 1) / NormDiv;

  // Register reset values.
  localparam logic [15:0]        ResetWidth  = 16'd256;
  localparam logic [15:0]        ResetHeight = 16'd256;
  localparam logic [31:0]        ResetStep   = 32'h0001_0000;
  localparam logic signed [31:0] ResetBase   = 32'sd0;
  localparam logic signed [31:0] ResetScale  = 32'sh0001_0000;

  typedef enum logic [2:0] {
    REG_RASTER_WIDTH  = 3'd0,
    REG_RASTER_HEIGHT = 3'd1,
    REG_COLUMN_STEP   = 3'd2,
    REG_ROW_STEP      = 3'd3,
    REG_HEIGHT_BASE   = 3'd4,
    REG_HEIGHT_SCALE  = 3'd5,
    REG_CUBIC_MODE    = 3'd6
  } reg_idx_t;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] col_step;
    logic [31:0] row_step;
  } geom_cfg_t;

  typedef struct packed {
    logic               cubic;
    logic signed [31:0] scale;
    logic signed [31:0] base;
  } level_cfg_t;

  typedef struct packed {
    logic done;
    logic error;
  } idx_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_LEVEL,
    ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    LV_IDLE,
    LV_RECIP,
    LV_FIX,
    LV_SQUARE,
    LV_CUBE,
    LV_SCALE,
    LV_SUM,
    LV_DONE
  } level_state_t;

endpackage

`default_nettype wire

@@ rtl/hgs_ram.sv @@
`default_nettype none

module hgs_ram #(
  parameter int WIDTH = hgs_pkg::PixelW,
  parameter int DEPTH = hgs_pkg::PixelDepth
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/hgs_index.sv @@
`default_nettype none

module hgs_index #(
  parameter int PIXEL_DEPTH = hgs_pkg::PixelDepth
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [15:0]                    col,
  input  wire logic [15:0]                    row,
  input  wire hgs_pkg::geom_cfg_t             cfg,
  output hgs_pkg::idx_status_t                status,
  output logic [$clog2(PIXEL_DEPTH)-1:0]      addr
);

  localparam int AW = $clog2(PIXEL_DEPTH);

  logic               v1, v2, v3;
  logic               err_q;
  logic [31:0]        x_q, y_q;
  logic signed [50:0] prod_q;

  logic [47:0]        x_prod, y_prod;
  logic signed [33:0] dy;
  logic signed [50:0] idx_sum;

  // Stage one: grid point to pixel column and row.
  assign x_prod = 48'(col) * 48'(cfg.col_step);
  assign y_prod = 48'(row) * 48'(cfg.row_step);

  // Stage two: rows are stored bottom-up.
  assign dy = $signed({18'd0, cfg.height}) - 34'sd1 - $signed({2'd0, y_q});

  // Stage three: linear index and range check.
  assign idx_sum = prod_q + $signed({19'd0, x_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_q <= x_prod[47:16];
      y_q <= y_prod[47:16];
    end
    if (v1) begin
      prod_q <= dy * $signed({1'b0, cfg.width});
    end
    if (v2) begin
      err_q <= idx_sum[50] || (idx_sum >= $signed(51'(PIXEL_DEPTH)));
      addr  <= idx_sum[AW-1:0];
    end
  end

  assign status.done  = v3;
  assign status.error = err_q;

endmodule

`default_nettype wire

@@ rtl/hgs_level.sv @@
`default_nettype none

module hgs_level (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [hgs_pkg::PixelW-1:0] pixel,
  input  wire hgs_pkg::level_cfg_t       cfg,
  output logic                           done,
  output logic signed [31:0]             height
);

  localparam logic [50:0] CubeRound = 51'h0_8000_0000;

  hgs_pkg::level_state_t state, state_next;

  logic [9:0]         sum_q;
  logic [16:0]        q_q;
  logic [16:0]        v_q;
  logic [33:0]        sq_q;
  logic signed [49:0] p_q;

  logic [25:0]        num;
  logic [52:0]        recip_prod;
  logic [16:0]        q_inc;
  logic [26:0]        q_chk;
  logic [50:0]        cube;
  logic [50:0]        cube_rnd;
  logic signed [49:0] p_rnd;
  logic signed [34:0] h_sum;
  logic signed [31:0] h_sat;

  assign num        = {sum_q, 16'd0} + 26'(hgs_pkg::NormRound);
  assign recip_prod = 53'(num) * 53'(hgs_pkg::NormRecip);
  assign q_inc      = q_q + 17'd1;
  assign q_chk      = 27'(q_inc) * 27'(hgs_pkg::NormDiv);
  assign cube       = 51'(sq_q) * 51'(v_q);
  assign cube_rnd   = cube + CubeRound;

  // Round half up on the 16 dropped fraction bits, then add the offset.
  assign p_rnd = p_q + 50'sd32768;
  assign h_sum = $signed(35'(p_rnd >>> 16)) + $signed(35'(cfg.base));

  always_comb begin
    if (!h_sum[34] && (h_sum[33:31] != 3'b000)) begin
      h_sat = 32'sh7FFF_FFFF;
    end else if (h_sum[34] && (h_sum[33:31] != 3'b111)) begin
      h_sat = 32'sh8000_0000;
    end else begin
      h_sat = h_sum[31:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hgs_pkg::LV_IDLE:   if (start) state_next = hgs_pkg::LV_RECIP;
      hgs_pkg::LV_RECIP:  state_next = hgs_pkg::LV_FIX;
      hgs_pkg::LV_FIX: begin
        state_next = cfg.cubic ? hgs_pkg::LV_SQUARE : hgs_pkg::LV_SCALE;
      end
      hgs_pkg::LV_SQUARE: state_next = hgs_pkg::LV_CUBE;
      hgs_pkg::LV_CUBE:   state_next = hgs_pkg::LV_SCALE;
      hgs_pkg::LV_SCALE:  state_next = hgs_pkg::LV_SUM;
      hgs_pkg::LV_SUM:    state_next = hgs_pkg::LV_DONE;
      hgs_pkg::LV_DONE:   state_next = hgs_pkg::LV_IDLE;
      default:            state_next = hgs_pkg::LV_IDLE;
    endcase
  end

  always_comb begin
    done = (state == hgs_pkg::LV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hgs_pkg::LV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      hgs_pkg::LV_IDLE: begin
        if (start) begin
          sum_q <= 10'(pixel[23:16]) + 10'(pixel[15:8]) + 10'(pixel[7:0]);
        end
      end
      hgs_pkg::LV_RECIP: q_q <= recip_prod[hgs_pkg::NormShift +: 17];
      hgs_pkg::LV_FIX: begin
        // Take one more if the remainder still reaches the divisor.
        v_q <= ({1'b0, num} >= q_chk) ? q_inc : q_q;
      end
      hgs_pkg::LV_SQUARE: sq_q <= 34'(v_q) * 34'(v_q);
      hgs_pkg::LV_CUBE:   v_q <= cube_rnd[48:32];
      hgs_pkg::LV_SCALE:  p_q <= $signed({1'b0, v_q}) * cfg.scale;
      hgs_pkg::LV_SUM:    height <= h_sat;
      hgs_pkg::LV_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/heightmap_grid_sampler.sv @@
`default_nettype none

// Channel    Dir  Payload (lowest bit first)                         Transfer when
// s_* input  in   tdata: pixel_addr, red, green, blue, grid_column,  s_tvalid & s_tready
//                 grid_row; tuser: mode
// m_* result out  tdata: height; tuser: index_error                   m_tvalid & m_tready
// APB config in   registers at byte address 4*i, 32-bit data          psel & penable & pwrite
//
// A pixel write produces no result and leaves the block idle for the next item.
// A sample passes through the index pipeline (three stages, two of them
// multiplies), one pixel memory read and the normalize/cube/scale sequencer in
// the level unit, which shares no stages; cubic mode adds the square and cube
// steps, and an index outside the store skips the read and the level unit. No
// new item is taken until the result has been loaded into the output register.
// Reset is synchronous and clears control state only; the pixel memory is not
// cleared. A stalled result sits in the output register while further pixel
// writes and one more sample keep being accepted.

module heightmap_grid_sampler #(
  parameter int PIXEL_DEPTH = hgs_pkg::PixelDepth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // pixel_addr[15:0], red[23:16], green[31:24], blue[39:32],
  // grid_column[55:40], grid_row[71:56]
  input  wire logic [hgs_pkg::InDataW-1:0]   s_tdata,
  // mode
  input  wire logic                          s_tuser,

  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // height[31:0]
  output logic [hgs_pkg::OutDataW-1:0]       m_tdata,
  // index_error
  output logic                               m_tuser,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hgs_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [hgs_pkg::ApbDataW-1:0]  pwdata,
  output logic [hgs_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);

  localparam int AW = $clog2(PIXEL_DEPTH);

  // Configuration registers.
  logic [15:0]        raster_width;
  logic [15:0]        raster_height;
  logic [31:0]        column_step;
  logic [31:0]        row_step;
  logic signed [31:0] height_base;
  logic signed [31:0] height_scale;
  logic               cubic_mode;

  logic              cfg_wr;
  hgs_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = hgs_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_width  <= hgs_pkg::ResetWidth;
      raster_height <= hgs_pkg::ResetHeight;
      column_step   <= hgs_pkg::ResetStep;
      row_step      <= hgs_pkg::ResetStep;
      height_base   <= hgs_pkg::ResetBase;
      height_scale  <= hgs_pkg::ResetScale;
      cubic_mode    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hgs_pkg::REG_RASTER_WIDTH:  raster_width  <= pwdata[15:0];
        hgs_pkg::REG_RASTER_HEIGHT: raster_height <= pwdata[15:0];
        hgs_pkg::REG_COLUMN_STEP:   column_step   <= pwdata;
        hgs_pkg::REG_ROW_STEP:      row_step      <= pwdata;
        hgs_pkg::REG_HEIGHT_BASE:   height_base   <= $signed(pwdata);
        hgs_pkg::REG_HEIGHT_SCALE:  height_scale  <= $signed(pwdata);
        hgs_pkg::REG_CUBIC_MODE:    cubic_mode    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hgs_pkg::REG_RASTER_WIDTH:  prdata = {16'd0, raster_width};
      hgs_pkg::REG_RASTER_HEIGHT: prdata = {16'd0, raster_height};
      hgs_pkg::REG_COLUMN_STEP:   prdata = column_step;
      hgs_pkg::REG_ROW_STEP:      prdata = row_step;
      hgs_pkg::REG_HEIGHT_BASE:   prdata = height_base;
      hgs_pkg::REG_HEIGHT_SCALE:  prdata = height_scale;
      hgs_pkg::REG_CUBIC_MODE:    prdata = {31'd0, cubic_mode};
      default:                    prdata = '0;
    endcase
  end

  hgs_pkg::geom_cfg_t  geom_cfg;
  hgs_pkg::level_cfg_t level_cfg;

  assign geom_cfg.width     = raster_width;
  assign geom_cfg.height    = raster_height;
  assign geom_cfg.col_step  = column_step;
  assign geom_cfg.row_step  = row_step;
  assign level_cfg.cubic    = cubic_mode;
  assign level_cfg.scale    = height_scale;
  assign level_cfg.base     = height_base;

  // Input fields.
  logic [15:0] pixel_addr;
  logic [7:0]  red, green, blue;
  logic [15:0] grid_column, grid_row;

  assign pixel_addr  = s_tdata[15:0];
  assign red         = s_tdata[23:16];
  assign green       = s_tdata[31:24];
  assign blue        = s_tdata[39:32];
  assign grid_column = s_tdata[55:40];
  assign grid_row    = s_tdata[71:56];

  logic in_xfer;
  logic is_sample;

  assign in_xfer   = s_tvalid && s_tready;
  assign is_sample = (s_tuser == hgs_pkg::MODE_SAMPLE);

  // Pixel memory. Writes happen only in the idle state and reads only while a
  // sample is in flight, so the two ports never touch the store in the same
  // cycle and no forwarding is needed.
  logic                       ram_we;
  logic                       ram_re;
  logic [AW-1:0]              idx_addr;
  logic [hgs_pkg::PixelW-1:0] ram_rdata;

  assign ram_we = in_xfer && !is_sample && ({16'd0, pixel_addr} < 32'(PIXEL_DEPTH));

  hgs_ram #(
    .WIDTH (hgs_pkg::PixelW),
    .DEPTH (PIXEL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(pixel_addr)),
    .wdata ({red, green, blue}),
    .re    (ram_re),
    .raddr (idx_addr),
    .rdata (ram_rdata)
  );

  // Grid point to pixel index.
  logic                 idx_start;
  hgs_pkg::idx_status_t idx_stat;

  assign idx_start = in_xfer && is_sample;

  hgs_index #(
    .PIXEL_DEPTH (PIXEL_DEPTH)
  ) u_index (
    .clk    (clk),
    .rst    (rst),
    .start  (idx_start),
    .col    (grid_column),
    .row    (grid_row),
    .cfg    (geom_cfg),
    .status (idx_stat),
    .addr   (idx_addr)
  );

  // Brightness to height.
  logic               lv_start;
  logic               lv_done;
  logic signed [31:0] lv_height;

  hgs_level u_level (
    .clk    (clk),
    .rst    (rst),
    .start  (lv_start),
    .pixel  (ram_rdata),
    .cfg    (level_cfg),
    .done   (lv_done),
    .height (lv_height)
  );

  // Sample sequencer.
  hgs_pkg::top_state_t state, state_next;
  logic                out_load;
  logic                err_q;

  always_comb begin
    state_next = state;
    unique case (state)
      hgs_pkg::ST_IDLE:  if (idx_start) state_next = hgs_pkg::ST_INDEX;
      hgs_pkg::ST_INDEX: begin
        if (idx_stat.done) begin
          state_next = idx_stat.error ? hgs_pkg::ST_OUT : hgs_pkg::ST_READ;
        end
      end
      hgs_pkg::ST_READ:  state_next = hgs_pkg::ST_LEVEL;
      hgs_pkg::ST_LEVEL: if (lv_done) state_next = hgs_pkg::ST_OUT;
      hgs_pkg::ST_OUT:   if (out_load) state_next = hgs_pkg::ST_IDLE;
      default:           state_next = hgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    ram_re   = 1'b0;
    lv_start = 1'b0;
    out_load = 1'b0;
    unique case (state)
      hgs_pkg::ST_IDLE:  s_tready = 1'b1;
      hgs_pkg::ST_INDEX: ram_re   = idx_stat.done && !idx_stat.error;
      hgs_pkg::ST_READ:  lv_start = 1'b1;
      hgs_pkg::ST_LEVEL: begin
      end
      hgs_pkg::ST_OUT:   out_load = !m_tvalid || m_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hgs_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // A sample that falls outside the store reports zero height.
  always_ff @(posedge clk) begin
    if (idx_stat.done && (state == hgs_pkg::ST_INDEX)) begin
      err_q <= idx_stat.error;
    end
    if (out_load) begin
      m_tdata <= err_q ? '0 : lv_height;
      m_tuser <= err_q;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("pixel memory read and write in the same cycle");

  assert property (@(posedge clk) disable iff (rst) (idx_start |-> ##3 idx_stat.done))
    else $error("index unit did not finish three cycles after a sample transfer");

  assert property (@(posedge clk) disable iff (rst) (lv_start |-> $past(ram_re)))
    else $error("level unit started without a preceding pixel read");

  assert property (@(posedge clk) disable iff (rst) ((m_tvalid && m_tuser) |-> (m_tdata == '0)))
    else $error("out-of-store result carries a nonzero height");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Stream-level check of heightmap_grid_sampler.
//
// Items are built ahead of time by the sequence in the main initial block and
// put on pending_items. A clocked driver presents them on the input channel and,
// on each write transfer, updates the testbench's own copy of the pixel store.
// For every sample request it also pushes the predicted result onto
// expected_heights. A clocked monitor pops one prediction for each output
// transfer and compares it field by field.
//
// Register settings change only while the block is idle: after reset, and
// between phases once every predicted result has come back and a settling wait
// has passed, because a trailing pixel write gives no result to wait on.
module tb_top;
  import hgs_pkg::*;

  // One input item, with the fields unpacked.
  typedef struct {
    mode_t       mode;
    logic [15:0] pixel_addr;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] grid_column;
    logic [15:0] grid_row;
  } hm_item_t;

  // One result item.
  typedef struct {
    logic [31:0] height;
    logic        index_error;
  } sample_result_t;

  // This margin covers a pixel write that may still be in flight after the
  // last result.
  localparam int SettleCycles = 16;

  // The receiver stops for a long stretch once this many input transfers have
  // happened. Idling on both sides is switched off inside the quiet window.
  localparam int HoldAfterXfers = 300;
  localparam int HoldCycles     = 400;
  localparam int QuietFrom      = 700;
  localparam int QuietTo        = 1000;
  localparam int IdlePercent    = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // pixel_addr[15:0], red[23:16], green[31:24], blue[39:32],
  // grid_column[55:40], grid_row[71:56]
  logic [InDataW-1:0]  s_tdata = '0;
  // mode
  logic                s_tuser = 1'b0;

  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // height[31:0]
  logic [OutDataW-1:0] m_tdata;
  // index_error
  logic                m_tuser;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  heightmap_grid_sampler DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time; a correct run needs well under a tenth of it.
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Register settings as the block should hold them, starting at reset values.
  logic [15:0]        cfg_width    = ResetWidth;
  logic [15:0]        cfg_height   = ResetHeight;
  logic [31:0]        cfg_col_step = ResetStep;
  logic [31:0]        cfg_row_step = ResetStep;
  logic signed [31:0] cfg_base     = ResetBase;
  logic signed [31:0] cfg_scale    = ResetScale;
  logic               cfg_cubic    = 1'b0;

  // The predicted contents of the pixel store, updated on pixel write transfers.
  logic [23:0] pixel_shadow [0:PixelDepth-1];
  // Pixels that the item sequence has already queued a write for. The sequence
  // uses it so that no sample ever reads a pixel that was never written.
  bit          pixel_queued [0:PixelDepth-1];

  hm_item_t       pending_items[$];
  sample_result_t expected_heights[$];
  hm_item_t       cur_item;

  int items_queued = 0;
  int in_xfers     = 0;
  int mismatches   = 0;
  int n_samples    = 0;
  int n_flagged    = 0;
  int n_writes     = 0;
  int n_settings   = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  function automatic bit quiet_window();
    return in_xfers >= QuietFrom && in_xfers < QuietTo;
  endfunction

  // Pixel index of a grid point under the current settings. The products are
  // formed at full width, so the index can be far outside the store on either
  // side, and a zero width or height simply enters the formula as given.
  function automatic longint grid_pixel_index(logic [15:0] col, logic [15:0] row);
    logic [63:0] xp;
    logic [63:0] yp;
    longint      x;
    longint      y;
    longint      w;
    longint      h;
    xp = ({48'd0, col} * {32'd0, cfg_col_step}) >> 16;
    yp = ({48'd0, row} * {32'd0, cfg_row_step}) >> 16;
    x = xp;
    y = yp;
    w = {48'd0, cfg_width};
    h = {48'd0, cfg_height};
    return x + (h - 1 - y) * w;
  endfunction

  // Expected result of one sample request.
  function automatic sample_result_t predict_height(hm_item_t it);
    sample_result_t    res;
    longint            idx;
    logic [23:0]       px;
    longint unsigned   level_sum;
    longint unsigned   norm;
    longint            product;
    longint            hgt;
    idx = grid_pixel_index(it.grid_column, it.grid_row);
    if (idx < 0 || idx >= PixelDepth) begin
      res.height      = '0;
      res.index_error = 1'b1;
      return res;
    end
    px = pixel_shadow[idx];
    level_sum = 64'(px[23:16]) + 64'(px[15:8]) + 64'(px[7:0]);
    // Brightness as UQ1.16 with rounding half up; full white gives exactly 1.0.
    norm = (level_sum * 65536 + 382) / 765;
    if (cfg_cubic)
      norm = (norm * norm * norm + 64'h8000_0000) >> 32;
    product = longint'(norm) * longint'(cfg_scale);
    // Arithmetic shift gives the floor for negative products as well.
    hgt = ((product + 64'sd32768) >>> 16) + longint'(cfg_base);
    if (hgt > 64'sd2147483647)
      hgt = 64'sd2147483647;
    if (hgt < -64'sd2147483648)
      hgt = -64'sd2147483648;
    res.height      = hgt[31:0];
    res.index_error = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] mismatch on %s: expected %08h, got %08h", $time, what, want, got);
    mismatches++;
  endtask

  // Input driver. tvalid stays up until the transfer happens; between items it
  // drops at random now and then.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (cur_item.mode == MODE_WRITE) begin
          // The address field cannot reach past the store, so every write lands.
          pixel_shadow[cur_item.pixel_addr] = {cur_item.red, cur_item.green, cur_item.blue};
          n_writes++;
        end else begin
          expected_heights.push_back(predict_height(cur_item));
        end
        in_xfers++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 &&
            (quiet_window() || $urandom_range(0, 99) >= IdlePercent)) begin
          cur_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_item.grid_row, cur_item.grid_column, cur_item.blue,
                       cur_item.green, cur_item.red, cur_item.pixel_addr};
          s_tuser  <= cur_item.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready. Once the input side has moved enough items the receiver
  // holds off for a long stretch, so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && in_xfers >= HoldAfterXfers) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet_window() || $urandom_range(0, 99) >= IdlePercent;
    end
  end

  // Output monitor: each result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    sample_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_heights.size() == 0) begin
        report_mismatch("result with no request pending", '0, m_tdata);
      end else begin
        want = expected_heights.pop_front();
        if (m_tdata !== want.height)
          report_mismatch("height", want.height, m_tdata);
        if (m_tuser !== want.index_error)
          report_mismatch("index_error", 32'(want.index_error), 32'(m_tuser));
        n_samples++;
        if (m_tuser === 1'b1)
          n_flagged++;
      end
    end
  end

  // Register write: setup cycle, then access cycle; the write lands at the edge
  // that ends the access cycle.
  task automatic program_register(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RASTER_WIDTH:  cfg_width    = value[15:0];
      REG_RASTER_HEIGHT: cfg_height   = value[15:0];
      REG_COLUMN_STEP:   cfg_col_step = value;
      REG_ROW_STEP:      cfg_row_step = value;
      REG_HEIGHT_BASE:   cfg_base     = value;
      REG_HEIGHT_SCALE:  cfg_scale    = value;
      REG_CUBIC_MODE:    cfg_cubic    = value[0];
      default: ;
    endcase
  endtask

  // Reads every register back and compares it with the expected setting.
  task automatic verify_registers();
    reg_idx_t    idx;
    logic [31:0] want;
    for (int i = REG_RASTER_WIDTH; i <= REG_CUBIC_MODE; i++) begin
      idx = reg_idx_t'(i);
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
        REG_RASTER_WIDTH:  want = {16'd0, cfg_width};
        REG_RASTER_HEIGHT: want = {16'd0, cfg_height};
        REG_COLUMN_STEP:   want = cfg_col_step;
        REG_ROW_STEP:      want = cfg_row_step;
        REG_HEIGHT_BASE:   want = cfg_base;
        REG_HEIGHT_SCALE:  want = cfg_scale;
        default:           want = {31'd0, cfg_cubic};
      endcase
      if (prdata !== want)
        report_mismatch($sformatf("register %s readback", idx.name()), want, prdata);
    end
    n_settings++;
  endtask

  // Queues a pixel write. The grid fields play no part and carry random bits.
  task automatic push_write(input int addr, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    hm_item_t it;
    it.mode        = MODE_WRITE;
    it.pixel_addr  = addr[15:0];
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    it.grid_column = $urandom_range(0, 65535);
    it.grid_row    = $urandom_range(0, 65535);
    pixel_queued[it.pixel_addr] = 1'b1;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Queues a sample request. If it lands on a pixel that has no write yet, a
  // write of a random color goes ahead of it. The pixel fields carry random bits.
  task automatic push_sample(input int col, input int row);
    hm_item_t it;
    longint   idx;
    it.mode        = MODE_SAMPLE;
    it.grid_column = col[15:0];
    it.grid_row    = row[15:0];
    it.pixel_addr  = $urandom_range(0, 65535);
    it.red         = $urandom_range(0, 255);
    it.green       = $urandom_range(0, 255);
    it.blue        = $urandom_range(0, 255);
    idx = grid_pixel_index(it.grid_column, it.grid_row);
    if (idx >= 0 && idx < PixelDepth && !pixel_queued[idx])
      push_write(int'(idx), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Waits until every queued item has gone in and every result has come out,
  // then lets a trailing pixel write settle.
  task automatic wait_for_drain();
    while (in_xfers != items_queued || expected_heights.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_all(input int w, input int h, input logic [31:0] cs,
                             input logic [31:0] rs, input logic [31:0] base,
                             input logic [31:0] scale, input bit cubic);
    program_register(REG_RASTER_WIDTH, w);
    program_register(REG_RASTER_HEIGHT, h);
    program_register(REG_COLUMN_STEP, cs);
    program_register(REG_ROW_STEP, rs);
    program_register(REG_HEIGHT_BASE, base);
    program_register(REG_HEIGHT_SCALE, scale);
    program_register(REG_CUBIC_MODE, cubic);
    verify_registers();
  endtask

  // One phase with a random, well-formed geometry as software would set it up:
  // steps are size / (count + 1). Most requests walk that grid, a few use wild
  // grid points, and writes go mostly into the image and sometimes anywhere.
  task automatic run_random_phase(input int n_items);
    int          w;
    int          h;
    int          n_cols;
    int          n_rows;
    int          pick;
    logic [31:0] scale;
    logic [31:0] base;
    w = ($urandom_range(0, 3) == 0) ? $urandom_range(1024, 16384) : $urandom_range(1, 400);
    h = $urandom_range(1, PixelDepth / w);
    if (h > 65535)
      h = 65535;
    n_cols = $urandom_range(1, 48);
    n_rows = $urandom_range(1, 48);
    if ($urandom_range(0, 3) == 0)
      scale = $urandom;
    else
      scale = $urandom_range(0, 1 << 20) * (($urandom_range(0, 1) != 0) ? -1 : 1);
    if ($urandom_range(0, 3) == 0)
      base = $urandom;
    else
      base = $urandom_range(0, 1 << 22) * (($urandom_range(0, 1) != 0) ? -1 : 1);
    program_all(w, h, (longint'(w) << 16) / (n_cols + 1), (longint'(h) << 16) / (n_rows + 1),
                base, scale, $urandom_range(0, 1));
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        push_sample($urandom_range(0, n_cols + 1), $urandom_range(0, n_rows + 1));
      else if (pick < 70)
        push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
      else if (pick < 95)
        push_write($urandom_range(0, w * h - 1), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      else
        push_write($urandom_range(0, 65535), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a 256 by 256 image with unit steps, so a grid point maps
    // straight to a pixel. Corners of the store, black and full white, and
    // indexes just past either end of the store.
    verify_registers();
    push_write(0, 8'h00, 8'h00, 8'h00);
    push_write(65535, 8'hFF, 8'hFF, 8'hFF);
    push_write(16'h00FF, 8'h12, 8'h34, 8'h56);
    push_write(16'hFF00, 8'hAA, 8'h55, 8'h7F);
    push_write(16'h5A5A, 8'hA5, 8'h5A, 8'hC3);
    push_write(16'hA5A5, 8'h5A, 8'hA5, 8'h3C);
    push_sample(0, 255);
    push_sample(255, 0);
    push_sample(255, 255);
    push_sample(0, 0);
    push_sample(8'h5A, 8'hA5);
    push_sample(8'hA5, 8'h5A);
    push_sample(0, 256);
    push_sample(256, 0);
    push_sample(65535, 65535);
    push_sample(65535, 0);
    wait_for_drain();

    // One very wide row with a zero row step and the largest gain and offset:
    // black returns the offset, white saturates upward.
    program_all(65535, 1, 32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_sample(0, 0);
    push_sample(65535, 65535);
    push_sample(16'h5A5A, 7);
    wait_for_drain();

    // One very tall column with the largest steps, cubic mode and the most
    // negative gain and offset: white saturates downward, and neighbors of the
    // valid point fall outside the store on both sides.
    program_all(1, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
    push_write(65534, 8'hFF, 8'hFF, 8'hFF);
    push_sample(0, 0);
    push_sample(1, 0);
    push_sample(0, 1);
    push_sample(65535, 65535);
    wait_for_drain();

    // Zero width and height: the row term vanishes and the index is the column.
    program_all(0, 0, 32'h0001_0000, $urandom, $urandom_range(0, 1 << 20),
                $urandom_range(0, 1 << 18), 1'b1);
    for (int k = 0; k < 6; k++)
      push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
    wait_for_drain();

    for (int p = 0; p < 8; p++)
      run_random_phase(130);

    $display("Checked %0d sample results (%0d outside the store) and %0d pixel writes",
             n_samples, n_flagged, n_writes);
    $display("over %0d register settings, with extreme sizes, steps, gains and a long hold.",
             n_settings);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hgs_pkg.sv
rtl/hgs_ram.sv
rtl/hgs_index.sv
rtl/hgs_level.sv
rtl/heightmap_grid_sampler.sv
tb/tb_top.sv
